### hw/rtl/cppt_pkg.sv
// shared constants for the convex polygon point test unit
// no dependencies; used by convex_polygon_point_test_unit
`timescale 1ns / 1ps

package cppt_pkg;

    // defaults for the top level parameters
    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 12;

    // vertex_count register
    localparam int          VCOUNT_W   = 5;
    localparam logic [4:0]  VCOUNT_RST = 5'd4;
    localparam int          VIDX_W     = 4;

    // register indexes (word address bit above the byte offset)
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

### hw/rtl/convex_polygon_point_test_unit.sv
// convex polygon point test: vertex table plus a sequencer around one shared multiplier
// depends on cppt_pkg
`timescale 1ns / 1ps

//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------------
//  in       | input     | i_in_valid / o_in_stall  | i_func, i_vertex_index, i_coord_x/_y
//  out      | output    | o_out_valid / i_out_stall| o_inside_res
//  config   | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata (vertex_count)
//
// a vertex load writes the vertex table and gives no result
// a query with n vertices in use (n = min(vertex_count, MAX_VERTICES)) forms one cross
// product per edge, paced by the single multiplier doing two products per vertex; n below 2
// goes straight to the finish step; the input stalls until the result is set
// a finished query also waits while an earlier result is still stalled in the output register
// reset is synchronous, active low, restores vertex_count to 4; the vertex table is not cleared

module convex_polygon_point_test_unit #(
    parameter int MAX_VERTICES = cppt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cppt_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_func,
    input  logic [cppt_pkg::VIDX_W-1:0]  i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_inside_res,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int ZW = PW + 1;
    localparam int VW = 2 * COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME1,
        S_PRIME2,
        S_RUN,
        S_FIN
    } t_state;

    t_state r_state;

    logic [cppt_pkg::VCOUNT_W-1:0] r_vcount;

    logic [VW-1:0] r_mem [MAX_VERTICES];
    logic [VW-1:0] r_rd_data;
    logic [AW-1:0] r_raddr;

    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [1:0]    r_ph;

    logic signed [COORD_BITS-1:0] r_px, r_py, r_fx, r_fy, r_cx, r_cy;
    logic signed [DW-1:0]         r_ex, r_ey, r_rx, r_ry;
    logic signed [PW-1:0]         r_prod, r_p1;

    logic r_zv;
    logic r_prev_pos, r_prev_neg;
    logic r_changed;
    logic r_out_valid;
    logic r_inside;

    // input and config decode
    logic       in_xfer;
    logic       cfg_wr;
    logic [7:0] idx8;
    logic [7:0] cnt8;
    logic [CW-1:0] cnt_sat;
    logic       fin_go;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign idx8    = {{(8 - cppt_pkg::VIDX_W){1'b0}}, i_vertex_index};
    assign cnt8    = {{(8 - cppt_pkg::VCOUNT_W){1'b0}}, r_vcount};
    assign cnt_sat = (cnt8 > 8'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt8[CW-1:0];
    // finish step hands its result to a free output register
    assign fin_go  = (r_state == S_FIN) && !r_zv && (!r_out_valid || !i_out_stall);

    // next vertex: wraps to the first one on the last edge
    logic                         last_v;
    logic signed [COORD_BITS-1:0] nx, ny;
    logic [7:0]                   i_plus2;

    assign last_v  = ((r_i + CW'(1)) == r_n);
    assign nx      = last_v ? r_fx : $signed(r_rd_data[VW-1:COORD_BITS]);
    assign ny      = last_v ? r_fy : $signed(r_rd_data[COORD_BITS-1:0]);
    assign i_plus2 = 8'(r_i) + 8'd2;

    // shared multiplier: ex*ry in phase 1, ey*rx in phase 2
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;

    assign mul_a = (r_ph == 2'd1) ? r_ex : r_ey;
    assign mul_b = (r_ph == 2'd1) ? r_ry : r_rx;
    assign mul_p = mul_a * mul_b;

    // sign of the pending cross product and the change test against the previous sign
    logic signed [ZW-1:0] z;
    logic z_neg, z_pos, z_chg;

    assign z     = ZW'(r_p1) - ZW'(r_prod);
    assign z_neg = z[ZW-1];
    assign z_pos = !z_neg && (z != '0);
    assign z_chg = (z_pos && r_prev_neg) || (z_neg && r_prev_pos);

    // vertex table
    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_func == cppt_pkg::FUNC_LOAD) && (idx8 < 8'(MAX_VERTICES))) begin
            r_mem[idx8[AW-1:0]] <= {i_coord_x, i_coord_y};
        end
        r_rd_data <= r_mem[r_raddr];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= cppt_pkg::VCOUNT_RST;
        end else if (cfg_wr && (paddr[2] == cppt_pkg::REG_VERTEX_COUNT)) begin
            r_vcount <= pwdata[cppt_pkg::VCOUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cppt_pkg::REG_VERTEX_COUNT) ?
                    {{(32 - cppt_pkg::VCOUNT_W){1'b0}}, r_vcount} : 32'd0;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_zv        <= 1'b0;
            r_ph        <= 2'd0;
            r_i         <= '0;
            r_n         <= '0;
            r_raddr     <= '0;
            r_changed   <= 1'b0;
            r_prev_pos  <= 1'b0;
            r_prev_neg  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !fin_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_func == cppt_pkg::FUNC_QUERY)) begin
                        r_px       <= i_coord_x;
                        r_py       <= i_coord_y;
                        r_n        <= cnt_sat;
                        r_i        <= '0;
                        r_ph       <= 2'd0;
                        r_raddr    <= '0;
                        r_changed  <= 1'b0;
                        r_prev_pos <= 1'b0;
                        r_prev_neg <= 1'b0;
                        r_zv       <= 1'b0;
                        // fewer than two vertices give no pair to compare
                        r_state    <= (cnt_sat < CW'(2)) ? S_FIN : S_PRIME1;
                    end
                end
                S_PRIME1: begin
                    r_raddr <= AW'(1);
                    r_state <= S_PRIME2;
                end
                S_PRIME2: begin
                    r_fx    <= $signed(r_rd_data[VW-1:COORD_BITS]);
                    r_fy    <= $signed(r_rd_data[COORD_BITS-1:0]);
                    r_cx    <= $signed(r_rd_data[VW-1:COORD_BITS]);
                    r_cy    <= $signed(r_rd_data[COORD_BITS-1:0]);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    case (r_ph)
                        2'd0: begin
                            if (r_zv) begin
                                r_changed  <= r_changed | z_chg;
                                r_prev_pos <= z_pos;
                                r_prev_neg <= z_neg;
                                r_zv       <= 1'b0;
                            end
                            r_ex <= DW'(nx) - DW'(r_cx);
                            r_ey <= DW'(ny) - DW'(r_cy);
                            r_rx <= DW'(r_px) - DW'(r_cx);
                            r_ry <= DW'(r_py) - DW'(r_cy);
                            r_cx <= nx;
                            r_cy <= ny;
                            // prefetch the vertex after next
                            if (i_plus2 < 8'(r_n)) begin
                                r_raddr <= i_plus2[AW-1:0];
                            end
                            r_ph <= 2'd1;
                        end
                        2'd1: begin
                            r_prod <= mul_p;
                            r_ph   <= 2'd2;
                        end
                        2'd2: begin
                            r_p1   <= r_prod;
                            r_prod <= mul_p;
                            r_zv   <= 1'b1;
                            r_ph   <= 2'd0;
                            if (last_v) begin
                                r_state <= S_FIN;
                            end else begin
                                r_i <= r_i + CW'(1);
                            end
                        end
                        default: begin
                            r_ph <= 2'd0;
                        end
                    endcase
                end
                S_FIN: begin
                    if (r_zv) begin
                        r_changed <= r_changed | z_chg;
                        r_zv      <= 1'b0;
                    end else if (fin_go) begin
                        r_inside    <= !r_changed;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_inside;

    // vertex counter stays inside the polygon while walking it
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_i < r_n))
        else $error("vertex counter ran past vertex count");

    // a result only appears from the finish step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside finish step");

    // no cross product is left pending once the sequencer is idle
    a_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_zv)
        else $error("pending cross product in idle");

    // a query leaves the idle state only through a transfer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !in_xfer) |=> (r_state == S_IDLE))
        else $error("sequencer started without a transfer");

endmodule

### test/convex_polygon_point_test_unit_tb.sv
// testbench for convex_polygon_point_test_unit: directed table, then random convex polygons
// with queries, checked against an exact cross-product sign predictor; depends on cppt_pkg
`timescale 1ns / 1ps

module convex_polygon_point_test_unit_tb;

    localparam int  NV          = cppt_pkg::MAX_VERTICES_DEF;
    localparam int  CW          = cppt_pkg::COORD_BITS_DEF;
    localparam int  VIDX_W      = cppt_pkg::VIDX_W;
    localparam int  VCOUNT_W    = cppt_pkg::VCOUNT_W;
    localparam int  CMIN        = -(1 << (CW - 1));
    localparam int  CMAX        = (1 << (CW - 1)) - 1;
    localparam int  SETTLE      = 3 * NV + 4 + 8;
    localparam int  STALL_LIMIT = 5000;
    localparam int  ITEM_TARGET = 650;
    localparam real TWO_PI      = 6.28318530717959;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic              func;
        logic [VIDX_W-1:0] idx;
        t_coord            x;
        t_coord            y;
        logic              typed;
        logic              typed_res;
    } t_vec_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               i_func         = cppt_pkg::FUNC_LOAD;
    logic [VIDX_W-1:0]  i_vertex_index = '0;
    t_coord             i_coord_x      = '0;
    t_coord             i_coord_y      = '0;
    logic               i_out_stall    = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_inside_res;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state: shadow of the vertex table and of vertex_count
    t_coord              tab_x [NV];
    t_coord              tab_y [NV];
    logic [VCOUNT_W-1:0] vcount_shadow = cppt_pkg::VCOUNT_RST;

    logic     inside_q [$];
    t_vec_row vec_rows [$];
    logic     want_res;
    int       errors      = 0;
    int       items       = 0;
    int       idle_cycles = 0;
    bit       quiet       = 1'b0;

    convex_polygon_point_test_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #6 i_clk = ~i_clk;

    // exact z sign of edge x ray for every vertex in use; outside on a strict sign flip
    function automatic logic point_inside(t_coord px, t_coord py);
        int                     n;
        int                     j;
        int                     sgn;
        int                     prev_sgn;
        logic signed [CW:0]     ex, ey, rx, ry;
        logic signed [2*CW+2:0] z;
        logic                   res;
        n = (vcount_shadow > NV) ? NV : int'(vcount_shadow);
        res = 1'b1;
        prev_sgn = 0;
        for (int i = 0; i < n; i++) begin
            j = (i + 1 == n) ? 0 : i + 1;
            ex = tab_x[j] - tab_x[i];
            ey = tab_y[j] - tab_y[i];
            rx = px - tab_x[i];
            ry = py - tab_y[i];
            z = ex * ry - ey * rx;
            sgn = (z == 0) ? 0 : ((z < 0) ? -1 : 1);
            if (i > 0 && sgn * prev_sgn < 0) begin
                res = 1'b0;
            end
            prev_sgn = sgn;
        end
        return res;
    endfunction

    function automatic t_coord clamp_coord(int v);
        if (v < CMIN) begin
            return t_coord'(CMIN);
        end
        if (v > CMAX) begin
            return t_coord'(CMAX);
        end
        return t_coord'(v);
    endfunction

    function automatic t_coord rand_coord();
        t_coord c;
        c = t_coord'($urandom);
        return c;
    endfunction

    task automatic send_item(logic func, logic [VIDX_W-1:0] idx, t_coord x, t_coord y,
                             logic typed, logic typed_res);
        while (!quiet && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_vertex_index <= idx;
        i_coord_x      <= x;
        i_coord_y      <= y;
        do @(posedge i_clk); while (o_in_stall);
        if (func == cppt_pkg::FUNC_QUERY) begin
            inside_q.insert(inside_q.size(), typed ? typed_res : point_inside(x, y));
        end else begin
            tab_x[idx] = x;
            tab_y[idx] = y;
        end
        items++;
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {cppt_pkg::REG_VERTEX_COUNT, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_count_reg(logic [VCOUNT_W-1:0] want);
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[VCOUNT_W-1:0] !== want) begin
            errors++;
            $display("%0t: vertex_count read expected %0d got %0d", $time, want,
                     rd[VCOUNT_W-1:0]);
        end
    endtask

    // only while idle: drain results, let a running query finish, then write
    task automatic set_vertex_count(logic [VCOUNT_W-1:0] v);
        logic [31:0] rd;
        i_in_valid <= 1'b0;
        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        apb_access(1'b1, 32'(v), rd);
        vcount_shadow = v;
        @(posedge i_clk);
        check_count_reg(v);
    endtask

    task automatic add_row(logic func, int idx, int x, int y,
                           logic typed, logic typed_res);
        t_vec_row r;
        r = '{func, VIDX_W'(idx), t_coord'(x), t_coord'(y), typed, typed_res};
        vec_rows.insert(vec_rows.size(), r);
    endtask

    // one jittered regular polygon loaded in order, then a batch of queries around it
    task automatic polygon_round(int n_slots);
        t_coord px [NV];
        t_coord py [NV];
        int     cx, cy, r, k, k1, nq, span, qx, qy;
        real    dir, ang;
        case ($urandom_range(3))
            0:       r = $urandom_range(1, 12);
            1:       r = $urandom_range(13, 300);
            2:       r = $urandom_range(301, 1500);
            default: r = $urandom_range(1501, 3000);
        endcase
        cx = int'($urandom_range(0, 4095)) + CMIN;
        cy = int'($urandom_range(0, 4095)) + CMIN;
        dir = ($urandom_range(1) != 0) ? 1.0 : -1.0;
        for (k = 0; k < n_slots; k++) begin
            ang = dir * TWO_PI * (k + $urandom_range(70) / 100.0) / n_slots;
            px[k] = clamp_coord(cx + $rtoi(r * $cos(ang)));
            py[k] = clamp_coord(cy + $rtoi(r * $sin(ang)));
        end
        for (k = 0; k < n_slots; k++) begin
            // stray load now and then, may break the polygon
            if ($urandom_range(99) < 6) begin
                send_item(cppt_pkg::FUNC_LOAD, VIDX_W'($urandom), rand_coord(), rand_coord(),
                          1'b0, 1'b0);
            end
            send_item(cppt_pkg::FUNC_LOAD, VIDX_W'(k), px[k], py[k], 1'b0, 1'b0);
        end
        nq = $urandom_range(4, 10);
        span = r + r / 2 + 1;
        repeat (nq) begin
            k  = $urandom_range(n_slots - 1);
            k1 = (k + 1 == n_slots) ? 0 : k + 1;
            case ($urandom_range(4))
                0: begin
                    qx = cx + int'($urandom_range(2)) - 1;
                    qy = cy + int'($urandom_range(2)) - 1;
                end
                1: begin
                    qx = int'(px[k]);
                    qy = int'(py[k]);
                end
                2: begin
                    qx = (int'(px[k]) + int'(px[k1])) / 2;
                    qy = (int'(py[k]) + int'(py[k1])) / 2;
                end
                3: begin
                    qx = int'(rand_coord());
                    qy = int'(rand_coord());
                end
                default: begin
                    qx = cx + int'($urandom_range(2 * span)) - span;
                    qy = cy + int'($urandom_range(2 * span)) - span;
                end
            endcase
            if ($urandom_range(99) < 5) begin
                send_item(cppt_pkg::FUNC_LOAD, VIDX_W'($urandom), rand_coord(), rand_coord(),
                          1'b0, 1'b0);
            end
            send_item(cppt_pkg::FUNC_QUERY, VIDX_W'($urandom), clamp_coord(qx),
                      clamp_coord(qy), 1'b0, 1'b0);
        end
    endtask

    function automatic logic [VCOUNT_W-1:0] phase_count(int p);
        case (p)
            0:       return VCOUNT_W'(NV);
            1:       return VCOUNT_W'(3);
            2:       return '1;
            3:       return VCOUNT_W'(0);
            4:       return VCOUNT_W'(1);
            5:       return VCOUNT_W'(2);
            6:       return VCOUNT_W'(NV + 1);
            7:       return VCOUNT_W'(8);
            default: return ($urandom_range(9) == 0) ? VCOUNT_W'($urandom) :
                                                        VCOUNT_W'($urandom_range(3, NV));
        endcase
    endfunction

    // result side: compare each transfer with the oldest pending query, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (inside_q.size() == 0) begin
                errors++;
                $display("%0t: inside_res %0b with no query pending", $time, o_inside_res);
            end else begin
                want_res = inside_q.pop_front();
                if (o_inside_res !== want_res) begin
                    errors++;
                    $display("%0t: inside_res expected %0b got %0b", $time, want_res,
                             o_inside_res);
                end
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int p;
        int phase_start;
        int n_slots;
        logic [VCOUNT_W-1:0] cnt;
        t_vec_row r;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_count_reg(cppt_pkg::VCOUNT_RST);

        // square at the coordinate extremes: every point is inside or on it
        add_row(cppt_pkg::FUNC_LOAD,  0, CMIN, CMIN, 1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  1, CMAX, CMIN, 1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  2, CMAX, CMAX, 1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  3, CMIN, CMAX, 1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_QUERY, 0, 0,    0,    1'b1, 1'b1);
        add_row(cppt_pkg::FUNC_QUERY, 5, CMIN, CMIN, 1'b1, 1'b1);
        add_row(cppt_pkg::FUNC_QUERY, 10, CMAX, 0,   1'b1, 1'b1);
        add_row(cppt_pkg::FUNC_QUERY, 15, CMIN, CMAX, 1'b1, 1'b1);
        // small square, points inside, on an edge, on a vertex and outside
        add_row(cppt_pkg::FUNC_LOAD,  0, 0,    0,    1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  1, 10,   0,    1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  2, 10,   10,   1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  3, 0,    10,   1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_QUERY, 0, 5,    5,    1'b1, 1'b1);
        add_row(cppt_pkg::FUNC_QUERY, 0, 10,   10,   1'b1, 1'b1);
        add_row(cppt_pkg::FUNC_QUERY, 0, 5,    0,    1'b1, 1'b1);
        add_row(cppt_pkg::FUNC_QUERY, 0, 20,   5,    1'b1, 1'b0);
        add_row(cppt_pkg::FUNC_QUERY, 0, -5,   5,    1'b1, 1'b0);
        add_row(cppt_pkg::FUNC_QUERY, 0, CMIN, CMIN, 1'b1, 1'b0);
        add_row(cppt_pkg::FUNC_QUERY, 0, CMAX, CMAX, 1'b1, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD, 15, -1,   -1,   1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_LOAD,  8, CMAX, CMIN, 1'b0, 1'b0);
        add_row(cppt_pkg::FUNC_QUERY, 7, 11,   -1,   1'b1, 1'b0);

        foreach (vec_rows[i]) begin
            r = vec_rows[i];
            send_item(r.func, r.idx, r.x, r.y, r.typed, r.typed_res);
        end

        // first phase uses all slots, so every entry is written before any wider query
        p = 0;
        while (items < ITEM_TARGET) begin
            cnt = phase_count(p);
            set_vertex_count(cnt);
            quiet = (p == 2 || p == 3);
            n_slots = (cnt > NV) ? NV : ((cnt < 3) ? 3 : int'(cnt));
            phase_start = items;
            while (items - phase_start < 60) begin
                polygon_round(n_slots);
            end
            p++;
        end
        quiet = 1'b0;

        i_in_valid <= 1'b0;
        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/cppt_pkg.sv
hw/rtl/convex_polygon_point_test_unit.sv
test/convex_polygon_point_test_unit_tb.sv
